>>> rtl/core/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared widths, register indexes and reset values for the ribbon position
// to pitch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpp_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int FULL_W   = 16;
   localparam int FREQ_W   = 13;
   localparam int DIFF_W   = FREQ_W + 1;
   localparam int OCT_W    = 3;
   localparam int OCT_MAX  = 3;
   localparam int SHIFT_W  = 2;
   localparam int PITCH_W  = 16;

   localparam int MCAND_W    = FULL_W + FREQ_W;
   localparam int PROD_W     = MCAND_W + FREQ_W;
   localparam int DENS_W     = MCAND_W + 2;
   localparam int DIVN_W     = PROD_W + OCT_MAX;
   localparam int DEN_W      = DENS_W - 1 + OCT_MAX;
   localparam int Q_W        = PITCH_W;
   localparam int MUL_STEP_W = $clog2(FREQ_W);
   localparam int DIV_STEP_W = $clog2(Q_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_FULL_SCALE    = 2'd0;
   localparam csr_idx_type CSR_BASE_FREQ_MIN = 2'd1;
   localparam csr_idx_type CSR_BASE_FREQ_MAX = 2'd2;
   localparam csr_idx_type CSR_OCTAVE_SHIFT  = 2'd3;

   localparam logic [FULL_W-1:0] RST_FULL_SCALE = 16'd1023;
   localparam logic [FREQ_W-1:0] RST_FREQ_MIN   = 13'd110;
   localparam logic [FREQ_W-1:0] RST_FREQ_MAX   = 13'd880;
   localparam logic [OCT_W-1:0]  RST_OCTAVE     = 3'd0;

endpackage

`default_nettype wire

>>> rtl/core/rpp_serial_mul.sv
// ----------------------------------------------------------------------------
// rpp_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_serial_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rpp_pkg::MCAND_W-1:0] mcand,
   input  logic [rpp_pkg::FREQ_W-1:0]  mplier,
   output logic                        done,
   output logic [rpp_pkg::PROD_W-1:0]  product
);
   import rpp_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [MUL_STEP_W-1:0] step_ff;
   logic [PROD_W-1:0]     mcand_ff;
   logic [FREQ_W-1:0]     mplier_ff;
   logic [PROD_W-1:0]     prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == MUL_STEP_W'(FREQ_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= PROD_W'(mcand);
         mplier_ff <= mplier;
         prod_ff   <= '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

`default_nettype wire

>>> rtl/core/rpp_serial_div.sv
// ----------------------------------------------------------------------------
// rpp_serial_div
// Restoring divider, one quotient bit per cycle, saturating 16-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_serial_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpp_pkg::DIVN_W-1:0] dividend,
   input  logic [rpp_pkg::DEN_W-1:0]  divisor,
   output logic                       done,
   output logic [rpp_pkg::Q_W-1:0]    quotient
);
   import rpp_pkg::*;

   localparam int DVS_W = DEN_W + Q_W - 1;
   localparam int CMP_W = DEN_W + Q_W;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [DIVN_W-1:0]     rem_ff;
   logic [DVS_W-1:0]      dvs_ff;
   logic [Q_W-1:0]        quot_ff;

   logic                  sat;
   logic [DVS_W-1:0]      rem_ext;
   logic [DVS_W-1:0]      rem_sub;
   logic                  ge;

   // quotient would not fit in Q_W bits
   assign sat     = {{(CMP_W - DIVN_W){1'b0}}, dividend} >= {divisor, {Q_W{1'b0}}};
   assign rem_ext = {{(DVS_W - DIVN_W){1'b0}}, rem_ff};
   assign ge      = rem_ext >= dvs_ff;
   assign rem_sub = rem_ext - dvs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= '0;
            busy_ff <= !sat;
            done_ff <= sat;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == DIV_STEP_W'(Q_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         dvs_ff  <= {divisor, {(Q_W - 1){1'b0}}};
         quot_ff <= sat ? '1 : '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_sub[DIVN_W-1:0];
         end
         quot_ff <= {quot_ff[Q_W-2:0], ge};
         dvs_ff  <= dvs_ff >> 1;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

>>> rtl/core/ribbon_position_to_pitch_unit.sv
// ----------------------------------------------------------------------------
// ribbon_position_to_pitch_unit
// Released (zero) sample: result directly. Pressed sample: window sweep, a
// 16-step serial division for the mean, three 13-step serial multiplications
// and, if the denominator is positive, a second division. One sample in
// flight: next beat taken once the result is registered. Synchronous reset:
// window empty, registers at defaults, not playing, held pitch zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ribbon_position_to_pitch_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rpp_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rpp_pkg::PITCH_W-1:0]    rsp_pitch_hz,
   output logic                           rsp_pitch_update,
   output logic                           rsp_note_start,
   output logic                           rsp_note_end,
   output logic                           rsp_is_playing
);
   import rpp_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SUM     = 4'd1;
   localparam logic [3:0] S_SUMEND  = 4'd2;
   localparam logic [3:0] S_MEAN_GO = 4'd3;
   localparam logic [3:0] S_MEAN    = 4'd4;
   localparam logic [3:0] S_MUL1    = 4'd5;
   localparam logic [3:0] S_MUL2    = 4'd6;
   localparam logic [3:0] S_MUL3    = 4'd7;
   localparam logic [3:0] S_DIV_GO  = 4'd8;
   localparam logic [3:0] S_DIV     = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [FULL_W-1:0]       full_ff;
   logic [FREQ_W-1:0]       fmin_ff;
   logic [FREQ_W-1:0]       fmax_ff;
   logic [OCT_W-1:0]        oct_ff;

   logic [SAMPLE_W-1:0]     window_mem [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic [SLOT_W-1:0]       wslot_ff;

   logic [3:0]              state_ff;
   logic [3:0]              state_in;
   logic [SLOT_W-1:0]       idx_ff;
   logic                    take_ff;
   logic [SAMPLE_W-1:0]     rd_data_ff;
   logic                    rd_ok_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    nz_ff;
   logic [Q_W-1:0]          mean_ff;
   logic [MCAND_W-1:0]      p1_ff;
   logic [PROD_W-1:0]       p2_ff;
   logic [DIVN_W-1:0]       num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [PITCH_W-1:0]      pitch_ff;
   logic [PITCH_W-1:0]      last_pitch_ff;
   logic                    playing_ff;

   logic                    rsp_valid_ff;
   logic [PITCH_W-1:0]      rsp_pitch_ff;
   logic                    rsp_update_ff;
   logic                    rsp_start_ff;
   logic                    rsp_end_ff;
   logic                    rsp_playing_ff;

   logic                    accept;
   logic                    out_free;
   logic                    commit;

   logic                    mul_start;
   logic [MCAND_W-1:0]      mul_a;
   logic [FREQ_W-1:0]       mul_b;
   logic                    mul_done;
   logic [PROD_W-1:0]       mul_prod;

   logic                    div_start;
   logic [DIVN_W-1:0]       div_a;
   logic [DEN_W-1:0]        div_b;
   logic                    div_done;
   logic [Q_W-1:0]          div_quot;

   logic [DIFF_W-1:0]       diff;
   logic                    diff_neg;
   logic [DIFF_W-1:0]       diff_abs;
   logic [DENS_W-1:0]       den_s;
   logic                    den_ok;
   logic [OCT_W-1:0]        oct_neg;
   logic [SHIFT_W-1:0]      pshift;
   logic [SHIFT_W-1:0]      nshift;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == S_DONE) && out_free;

   // span and sign of fmax - fmin
   assign diff     = {1'b0, fmax_ff} - {1'b0, fmin_ff};
   assign diff_neg = diff[DIFF_W-1];
   assign diff_abs = diff_neg ? (DIFF_W'(0) - diff) : diff;

   // mul_prod holds mean * |span| when mul_done rises in S_MUL3
   assign den_s  = diff_neg ? ({2'b00, p1_ff} - {2'b00, mul_prod[MCAND_W-1:0]})
                            : ({2'b00, p1_ff} + {2'b00, mul_prod[MCAND_W-1:0]});
   assign den_ok = !den_s[DENS_W-1] && (den_s != '0);

   // octave: -4 is clamped to -3
   assign oct_neg = OCT_W'(0) - oct_ff;
   assign pshift  = oct_ff[OCT_W-1] ? '0 : oct_ff[SHIFT_W-1:0];
   assign nshift  = !oct_ff[OCT_W-1] ? '0 :
                    (oct_neg[OCT_W-1] ? SHIFT_W'(OCT_MAX) : oct_neg[SHIFT_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= RST_FULL_SCALE;
         fmin_ff <= RST_FREQ_MIN;
         fmax_ff <= RST_FREQ_MAX;
         oct_ff  <= RST_OCTAVE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FULL_SCALE:    full_ff <= csr_wdata[FULL_W-1:0];
            CSR_BASE_FREQ_MIN: fmin_ff <= csr_wdata[FREQ_W-1:0];
            CSR_BASE_FREQ_MAX: fmax_ff <= csr_wdata[FREQ_W-1:0];
            CSR_OCTAVE_SHIFT:  oct_ff  <= csr_wdata[OCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_sample != '0) ? S_SUM : S_DONE;
            end
         end
         S_SUM: begin
            if (idx_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
               state_in = S_SUMEND;
            end
         end
         S_SUMEND: begin
            state_in = S_MEAN_GO;
         end
         S_MEAN_GO: begin
            div_start = 1'b1;
            div_a     = DIVN_W'(sum_ff);
            div_b     = DEN_W'(cnt_ff);
            state_in  = S_MEAN;
         end
         S_MEAN: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = MCAND_W'(full_ff);
               mul_b     = fmin_ff;
               state_in  = S_MUL1;
            end
         end
         S_MUL1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_prod[MCAND_W-1:0];
               mul_b     = fmax_ff;
               state_in  = S_MUL2;
            end
         end
         S_MUL2: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MCAND_W'(mean_ff);
               mul_b     = diff_abs[FREQ_W-1:0];
               state_in  = S_MUL3;
            end
         end
         S_MUL3: begin
            if (mul_done) begin
               state_in = den_ok ? S_DIV_GO : S_DONE;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            div_a     = num_ff;
            div_b     = den_ff;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         wslot_ff      <= '0;
         take_ff       <= 1'b0;
         playing_ff    <= 1'b0;
         last_pitch_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         take_ff  <= (state_ff == S_SUM);
         if (accept) begin
            valid_ff[wslot_ff] <= 1'b1;
            wslot_ff <= (wslot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : wslot_ff + 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            playing_ff   <= nz_ff;
            if (nz_ff) begin
               last_pitch_ff <= pitch_ff;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[wslot_ff] <= req_sample;
      end
      if (state_ff == S_SUM) begin
         rd_data_ff <= window_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         nz_ff  <= (req_sample != '0);
         idx_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (state_ff == S_SUM) begin
            idx_ff   <= idx_ff + 1'b1;
            rd_ok_ff <= valid_ff[idx_ff];
         end
         if (take_ff && rd_ok_ff && (rd_data_ff != '0)) begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if ((state_ff == S_MEAN) && div_done) begin
         mean_ff <= div_quot;
      end
      if ((state_ff == S_MUL1) && mul_done) begin
         p1_ff <= mul_prod[MCAND_W-1:0];
      end
      if ((state_ff == S_MUL2) && mul_done) begin
         p2_ff <= mul_prod;
      end
      if ((state_ff == S_MUL3) && mul_done) begin
         num_ff   <= DIVN_W'(p2_ff) << pshift;
         den_ff   <= DEN_W'(den_s[DENS_W-2:0]) << nshift;
         pitch_ff <= '1;
      end
      if ((state_ff == S_DIV) && div_done) begin
         pitch_ff <= div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_pitch_ff   <= nz_ff ? pitch_ff : last_pitch_ff;
         rsp_update_ff  <= nz_ff;
         rsp_start_ff   <= nz_ff && !playing_ff;
         rsp_end_ff     <= !nz_ff && playing_ff;
         rsp_playing_ff <= nz_ff;
      end
   end

   rpp_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   rpp_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pitch_hz     = rsp_pitch_ff;
   assign rsp_pitch_update = rsp_update_ff;
   assign rsp_note_start   = rsp_start_ff;
   assign rsp_note_end     = rsp_end_ff;
   assign rsp_is_playing   = rsp_playing_ff;

endmodule

`default_nettype wire
